// File: sv/mada_pkg.sv
// Shared types and constants for the moving average deviation alarm.
// No dependencies; every other file in sv/ imports this package.
package mada_pkg;

  localparam int WINDOW_SIZE_DEFAULT = 20;
  localparam int SAMPLE_W            = 12;
  localparam int PERIOD_W            = 8;
  localparam int CFG_INDEX_W         = 4;
  localparam int CFG_DATA_W          = 12;

  // Register map of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_THRESHOLD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_VALID_LOW       = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_VALID_HIGH      = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_PERIOD   = CFG_INDEX_W'(3);

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = SAMPLE_W'(32);
  localparam logic [SAMPLE_W-1:0] VALID_LOW_RESET  = SAMPLE_W'(16);
  localparam logic [SAMPLE_W-1:0] VALID_HIGH_RESET = SAMPLE_W'(1600);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET     = PERIOD_W'(10);

  typedef struct packed {
    logic [SAMPLE_W-1:0] alarm_threshold;
    logic [SAMPLE_W-1:0] valid_low;
    logic [SAMPLE_W-1:0] valid_high;
    logic [PERIOD_W-1:0] report_period;
  } mada_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FILL,
    ST_UPDATE,
    ST_SCALE,
    ST_REFINE,
    ST_CORRECT,
    ST_FINISH
  } mada_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // latch the incoming sample word
    logic fill_start;  // first in-range sample: preset sum, clear fill index
    logic fill_write;  // write one window entry with the sample
    logic update;      // ring read-modify-write and sum update
    logic scale;       // multiply sum magnitude by the reciprocal
    logic refine;      // quotient estimate and back-multiply
    logic correct;     // final quotient correction, load held average
    logic finish;      // load the result word
  } mada_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic filled;
    logic in_range;
    logic fill_last;
    logic out_free;
  } mada_status_t;

endpackage

// File: sv/moving_average_deviation_alarm.sv
// Boxcar moving average deviation alarm, one 12-bit temperature word per item
// (sixteenths of a degree), one result word per item. Until a sample lies strictly
// between valid_low and valid_high nothing is averaged and average/deviation read
// zero; that first in-range sample is written into every window entry, one entry
// per cycle, before the result load and the next accept. Once filled, each item
// steps through accept, ring slot read, ring write and sum update, then three steps
// of the divide by WINDOW_SIZE (reciprocal multiply, back-multiply, correction) and
// the result load. An out-of-range sample before the fill goes from accept and
// decide straight to the result load. One item is in flight at a time; the
// result sits in an output register, so a new word is taken while it waits.
// report_due pulses on sample report_period+1 and every report_period after;
// a zero period reports on every sample. cfg_ready is always high; write the
// registers only while the block is idle. Unknown register indexes are ignored.
// Depends on mada_pkg, mada_ctrl and mada_dpath.
module moving_average_deviation_alarm #(
  parameter int WINDOW_SIZE = mada_pkg::WINDOW_SIZE_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic        [mada_pkg::SAMPLE_W-1:0]   sample,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [mada_pkg::SAMPLE_W-1:0]   average,
  output logic        [mada_pkg::SAMPLE_W-1:0]   deviation,
  output logic                                   alarm,
  output logic                                   report_due,
  output logic                                   initialized,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [mada_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [mada_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mada_pkg::*;

  mada_cfg_t    cfg;
  mada_cmd_t    cmd;
  mada_status_t status;
  logic         busy;

  // always able to take a register write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_threshold <= THRESHOLD_RESET;
      cfg.valid_low       <= VALID_LOW_RESET;
      cfg.valid_high      <= VALID_HIGH_RESET;
      cfg.report_period   <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALARM_THRESHOLD: cfg.alarm_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_VALID_LOW:       cfg.valid_low       <= cfg_data[SAMPLE_W-1:0];
        CFG_VALID_HIGH:      cfg.valid_high      <= cfg_data[SAMPLE_W-1:0];
        CFG_REPORT_PERIOD:   cfg.report_period   <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stall whenever a word is being worked on
  assign in_stall = busy;

  mada_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  mada_dpath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .sample      (sample),
    .out_stall   (out_stall),
    .status      (status),
    .out_valid   (out_valid),
    .average     (average),
    .deviation   (deviation),
    .alarm       (alarm),
    .report_due  (report_due),
    .initialized (initialized)
  );

endmodule

// File: sv/mada_ctrl.sv
// Sequencing state machine for the moving average deviation alarm.
// Depends on mada_pkg for the state enum and the command/status structs.
module mada_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  mada_pkg::mada_status_t status,
  output mada_pkg::mada_cmd_t    cmd,
  output logic                  busy
);
  import mada_pkg::*;

  mada_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // window read of the ring slot lands at the end of this cycle
        if (status.filled) begin
          state_next = ST_UPDATE;
        end else if (status.in_range) begin
          cmd.fill_start = 1'b1;
          state_next     = ST_FILL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FILL: begin
        cmd.fill_write = 1'b1;
        if (status.fill_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_REFINE;
      end
      ST_REFINE: begin
        cmd.refine = 1'b1;
        state_next = ST_CORRECT;
      end
      ST_CORRECT: begin
        cmd.correct = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/mada_dpath.sv
// Datapath: window memory, running sum, constant divider, deviation and report logic.
// Depends on mada_pkg; driven by mada_ctrl through mada_cmd_t.
module mada_dpath #(
  parameter int WINDOW_SIZE = mada_pkg::WINDOW_SIZE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mada_pkg::mada_cmd_t                   cmd,
  input  mada_pkg::mada_cfg_t                   cfg,
  input  logic        [mada_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 out_stall,
  output mada_pkg::mada_status_t                status,
  output logic                                 out_valid,
  output logic        [mada_pkg::SAMPLE_W-1:0] average,
  output logic        [mada_pkg::SAMPLE_W-1:0] deviation,
  output logic                                 alarm,
  output logic                                 report_due,
  output logic                                 initialized
);
  import mada_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_SIZE);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_SIZE);
  localparam int MAG_W = SUM_W;
  localparam int K     = MAG_W;          // reciprocal scale 2^K
  localparam int Q_W   = SAMPLE_W + 1;   // quotient magnitude up to 2048
  localparam longint unsigned RECIP_L = (64'd1 << K) / WINDOW_SIZE;
  localparam logic [K-1:0]              RECIP  = RECIP_L[K-1:0];
  localparam logic [IDX_W-1:0]          LAST   = IDX_W'(WINDOW_SIZE - 1);
  localparam logic signed [SUM_W-1:0]   W_SUM  = SUM_W'(WINDOW_SIZE);
  localparam logic [MAG_W-1:0]          W_MAG  = MAG_W'(WINDOW_SIZE);

  logic [SAMPLE_W-1:0] mem [WINDOW_SIZE];
  logic [SAMPLE_W-1:0] rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;

  logic signed [SAMPLE_W-1:0] samp;
  logic signed [SUM_W-1:0]    sum;
  logic [IDX_W-1:0]           pos;
  logic [IDX_W-1:0]           fill_idx;
  logic                       filled;
  logic [SAMPLE_W-1:0]        held_avg;
  logic [MAG_W-1:0]           sum_mag;
  logic                       sum_neg;
  logic [2*K-1:0]             prod;
  logic [Q_W-1:0]             q0;
  logic [MAG_W-1:0]           qw;
  logic [PERIOD_W-1:0]        cnt;

  logic signed [SUM_W-1:0]    samp_ext;
  logic signed [SUM_W-1:0]    rd_ext;
  logic signed [SUM_W-1:0]    sum_next;
  logic [MAG_W-1:0]           rem;
  logic [Q_W-1:0]             quot;
  logic [Q_W-1:0]             avg_q;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_abs;
  logic [SAMPLE_W-1:0]        dev;
  logic                       report;

  // window memory, one write port, registered read at the ring slot
  assign wr_en   = cmd.fill_write | cmd.update;
  assign wr_addr = cmd.fill_write ? fill_idx : pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= samp;
    end
    rd_data <= mem[pos];
  end

  assign samp_ext = SUM_W'(samp);
  assign rd_ext   = SUM_W'($signed(rd_data));
  assign sum_next = sum - rd_ext + samp_ext;

  // quotient estimate is low by at most one
  assign rem   = sum_mag - qw;
  assign quot  = q0 + Q_W'(rem >= W_MAG);
  assign avg_q = sum_neg ? (~quot + Q_W'(1)) : quot;

  assign diff     = (SAMPLE_W+1)'(samp) - (SAMPLE_W+1)'($signed(held_avg));
  assign diff_abs = diff[SAMPLE_W] ? (~diff + (SAMPLE_W+1)'(1)) : diff;
  assign dev      = (samp == '0 || held_avg == '0) ? '0 : diff_abs[SAMPLE_W-1:0];
  assign report   = (cnt >= cfg.report_period);

  assign status.filled    = filled;
  assign status.in_range  = (samp > $signed(cfg.valid_low)) && (samp < $signed(cfg.valid_high));
  assign status.fill_last = (fill_idx == LAST);
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      samp <= $signed(sample);
    end
    if (cmd.fill_start) begin
      fill_idx <= '0;
    end else if (cmd.fill_write) begin
      fill_idx <= fill_idx + IDX_W'(1);
    end
    if (cmd.update) begin
      sum_neg <= sum_next[SUM_W-1];
      sum_mag <= sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);
    end
    if (cmd.scale) begin
      prod <= sum_mag * RECIP;
    end
    if (cmd.refine) begin
      q0 <= prod[K+Q_W-1:K];
      qw <= MAG_W'(prod[K+Q_W-1:K] * W_MAG);
    end
    if (cmd.finish) begin
      average    <= held_avg;
      deviation  <= dev;
      alarm      <= (dev >= cfg.alarm_threshold);
      report_due <= report;
      initialized <= filled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      pos       <= '0;
      filled    <= 1'b0;
      held_avg  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fill_start) begin
        sum <= samp_ext * W_SUM;
      end else if (cmd.update) begin
        sum <= sum_next;
      end
      if (cmd.fill_write && status.fill_last) begin
        filled <= 1'b1;
        pos    <= '0;
      end else if (cmd.update) begin
        pos <= (pos == LAST) ? '0 : pos + IDX_W'(1);
      end
      if (cmd.correct) begin
        held_avg <= avg_q[SAMPLE_W-1:0];
      end
      if (cmd.finish) begin
        cnt       <= report ? PERIOD_W'(1) : cnt + PERIOD_W'(1);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sim/tb_top.sv
// Self-checking bench for moving_average_deviation_alarm: drives temperature words,
// predicts each result word in-house and compares it field by field.
// Depends on mada_pkg and the RTL under sv/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mada_pkg::*;

  localparam int WINDOW      = WINDOW_SIZE_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;

  // Indexes past the register map; the block must ignore writes there.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = CFG_INDEX_W'(15);

  typedef struct {
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] deviation;
    logic                alarm;
    logic                report_due;
    logic                initialized;
  } expected_word_t;

  // Shapes of sample traffic used by the random part
  typedef enum int {
    SEG_STEADY,     // settles near one temperature, small noise
    SEG_EXTREME,    // window saturated at one rail, then the other rail
    SEG_NOISE,      // any 12-bit word
    SEG_STEP,       // one level, then a jump to another
    SEG_NEAR_ZERO   // values that keep the average at or near zero
  } segment_kind_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    sample      = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [SAMPLE_W-1:0]    average;
  logic [SAMPLE_W-1:0]    deviation;
  logic                   alarm;
  logic                   report_due;
  logic                   initialized;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  // Mirror of the register file, held as plain integers for the arithmetic
  int thresh_cfg = int'(THRESHOLD_RESET);
  int low_cfg    = int'($signed(VALID_LOW_RESET));
  int high_cfg   = int'($signed(VALID_HIGH_RESET));
  int period_cfg = int'(PERIOD_RESET);

  // Mirror of the averaging state
  int ring_buf [WINDOW];
  int sum_acc     = 0;
  int ring_idx    = 0;
  bit window_full = 1'b0;
  int avg_held    = 0;
  int sample_cnt  = 0;
  bit alarm_state = 1'b0;

  expected_word_t pending_results[$];
  expected_word_t head_word;
  int             failures    = 0;
  int             cycle_count = 0;
  bit             steady_run  = 1'b0;  // suppresses all idling on both sides

  moving_average_deviation_alarm #(
    .WINDOW_SIZE(WINDOW)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .average     (average),
    .deviation   (deviation),
    .alarm       (alarm),
    .report_due  (report_due),
    .initialized (initialized),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the handshake hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: about 28% of cycles, none during a steady run
  always @(posedge clk) begin
    out_stall <= !steady_run && ($urandom_range(99) < 28);
  end

  // Predict the result word for one accepted sample word. Until the window is
  // filled the held average stays zero; the filling word itself does not update
  // it. Deviation is forced to zero whenever sample or average is zero.
  function automatic void advance_average(input logic [SAMPLE_W-1:0] raw);
    int             s;
    int             diff;
    int             dev;
    bit             pulse;
    expected_word_t w;
    s     = $signed(raw);
    pulse = 1'b0;
    if (window_full) begin
      sum_acc            -= ring_buf[ring_idx];
      ring_buf[ring_idx]  = s;
      sum_acc            += s;
      avg_held            = sum_acc / WINDOW;  // truncates toward zero
      ring_idx            = (ring_idx + 1) % WINDOW;
    end else if (s > low_cfg && s < high_cfg) begin
      foreach (ring_buf[i]) ring_buf[i] = s;
      sum_acc     = s * WINDOW;
      ring_idx    = 0;
      window_full = 1'b1;
    end
    if (s != 0 && avg_held != 0) begin
      diff = s - avg_held;
      if (diff < 0) diff = -diff;
      dev = (diff > 4095) ? 4095 : diff;
    end else begin
      dev = 0;
    end
    // counter is compared before it counts, so the first pulse lands on word period+1
    if (sample_cnt >= period_cfg) begin
      pulse      = 1'b1;
      sample_cnt = 0;
    end
    sample_cnt  = (sample_cnt + 1) & 8'hFF;
    alarm_state = (dev >= thresh_cfg);
    w.average     = SAMPLE_W'(avg_held);
    w.deviation   = SAMPLE_W'(dev);
    w.alarm       = alarm_state;
    w.report_due  = pulse;
    w.initialized = window_full;
    pending_results.push_back(w);
  endfunction

  // Compare every accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no sample word outstanding");
        failures++;
      end else begin
        head_word = pending_results.pop_front();
        if (average !== head_word.average) begin
          $error("average: expected %0d, got %0d",
                 $signed(head_word.average), $signed(average));
          failures++;
        end
        if (deviation !== head_word.deviation) begin
          $error("deviation: expected %0d, got %0d", head_word.deviation, deviation);
          failures++;
        end
        if (alarm !== head_word.alarm) begin
          $error("alarm: expected %0b, got %0b", head_word.alarm, alarm);
          failures++;
        end
        if (report_due !== head_word.report_due) begin
          $error("report_due: expected %0b, got %0b", head_word.report_due, report_due);
          failures++;
        end
        if (initialized !== head_word.initialized) begin
          $error("initialized: expected %0b, got %0b",
                 head_word.initialized, initialized);
          failures++;
        end
      end
    end
  end

  // Sender idle cycles before the next word; mostly short, now and then long
  function automatic int idle_gap();
    if (steady_run || $urandom_range(99) >= 28) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 6);
    return $urandom_range(3, 1);
  endfunction

  // Offer one sample word and hold it until taken. Valid is left high on
  // return so a back-to-back word keeps it up; settle() drops it.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
    advance_average(value);
  endtask

  // Stop sending, let every predicted word come back, then allow the worst
  // per-word latency (a window fill) to pass before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (WINDOW + 8) @(posedge clk);
  endtask

  // One register write; cfg_valid stays high for a following write
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0]  data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALARM_THRESHOLD: thresh_cfg = data;
      CFG_VALID_LOW:       low_cfg    = $signed(data);
      CFG_VALID_HIGH:      high_cfg   = $signed(data);
      CFG_REPORT_PERIOD:   period_cfg = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  // Full register load from idle, plus a write to an unmapped index.
  // Period upper data bits are random; only the low byte counts.
  task automatic configure_all(input logic [CFG_DATA_W-1:0] thresh,
                               input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi,
                               input logic [PERIOD_W-1:0]   period);
    settle();
    write_register(CFG_ALARM_THRESHOLD, thresh);
    write_register(CFG_VALID_LOW, lo);
    write_register(CFG_VALID_HIGH, hi);
    write_register(CFG_REPORT_PERIOD,
                   CFG_DATA_W'(period) | (CFG_DATA_W'($urandom) & 12'hF00));
    write_register(CFG_INDEX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                   CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Random traffic built from segment shapes until at least total words sent
  task automatic stream_segments(input int total);
    int            sent;
    int            len;
    int            i;
    int            base;
    int            base_b;
    int            rail;
    segment_kind_t kind;
    sent = 0;
    while (sent < total) begin
      kind   = segment_kind_t'($urandom_range(4));
      len    = $urandom_range(40, 10);
      base   = int'($urandom_range(2880)) - 880;
      base_b = int'($urandom_range(2880)) - 880;
      rail   = $urandom_range(1) ? -2048 : 2047;
      if (kind == SEG_EXTREME) len = $urandom_range(WINDOW + 6, WINDOW + 2);
      for (i = 0; i < len; i++) begin
        case (kind)
          SEG_STEADY:  send_sample(SAMPLE_W'(base + int'($urandom_range(16)) - 8));
          SEG_EXTREME: send_sample(SAMPLE_W'((i < len - 3) ? rail : -1 - rail));
          SEG_NOISE:   send_sample(SAMPLE_W'($urandom));
          SEG_STEP:    send_sample(SAMPLE_W'((i < len / 2) ? base : base_b));
          default:     send_sample(SAMPLE_W'(int'($urandom_range(6)) - 3));
        endcase
      end
      sent += len;
    end
  endtask

  // Before the window fills: reset limits, then boundary and empty ranges.
  // Samples equal to a limit must not fill; neither may anything in an empty range.
  task automatic test_before_fill();
    send_sample(SAMPLE_W'(16));
    send_sample(SAMPLE_W'(1600));
    // zero threshold keeps the alarm up; zero period pulses every word
    configure_all(12'd0, 12'd16, 12'd1600, 8'd0);
    send_sample(SAMPLE_W'(-2048));
    send_sample(SAMPLE_W'(2047));
    send_sample(SAMPLE_W'(0));
    // adjacent limits leave nothing strictly between them
    configure_all(12'hFFF, 12'd100, 12'd101, 8'd1);
    send_sample(SAMPLE_W'(100));
    send_sample(SAMPLE_W'(101));
    send_sample(SAMPLE_W'(2047));
    // inverted limits at the rails
    configure_all(12'd2880, SAMPLE_W'(2047), SAMPLE_W'(-2048), 8'd255);
    send_sample(SAMPLE_W'(0));
    send_sample(12'hAAA);
    send_sample(12'h555);
  endtask

  // Fill with 1 so the following words walk the average through zero and
  // show truncation toward zero on a small negative sum.
  task automatic test_fill_and_rounding();
    configure_all(12'd32, SAMPLE_W'(-2048), SAMPLE_W'(2047), 8'd3);
    send_sample(SAMPLE_W'(1));      // fills; average still reads zero
    send_sample(SAMPLE_W'(0));      // zero sample
    send_sample(SAMPLE_W'(-5));     // average truncates to zero
    send_sample(SAMPLE_W'(-40));    // sum -28, average -1, alarm at 39
    send_sample(SAMPLE_W'(2047));
    send_sample(SAMPLE_W'(-2048));
    send_sample(SAMPLE_W'(2047));
  endtask

  task automatic test_random_traffic();
    configure_all(CFG_DATA_W'($urandom_range(600)), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), PERIOD_W'($urandom_range(12, 1)));
    stream_segments(250);
  endtask

  // No idling anywhere; saturate the window at one rail and swing to the other
  // so the deviation reaches 3890 (the new sample is in the average) against the top threshold.
  task automatic test_full_scale_run();
    configure_all(12'hFFF, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 8'd1);
    steady_run = 1'b1;
    repeat (WINDOW + 2) send_sample(SAMPLE_W'(-2048));
    send_sample(SAMPLE_W'(2047));
    stream_segments(125);
    settle();
    steady_run = 1'b0;
  endtask

  task automatic test_long_report_period();
    configure_all(CFG_DATA_W'($urandom_range(200)), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), 8'd255);
    stream_segments(300);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_before_fill();
    test_fill_and_rounding();
    test_random_traffic();
    test_full_scale_run();
    test_long_report_period();
    settle();
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
